// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk_i edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: rtl/core/plsel_pkg.sv
// ----------------------------------------------------------------------------
// plsel_pkg
// Shared types and constants of the peak list selector.
// ----------------------------------------------------------------------------
package plsel_pkg;

  localparam int unsigned POS_BITS_DEF  = 48;
  localparam int unsigned RANK_BITS_DEF = 16;

  localparam int unsigned MODE_BITS     = 2;
  localparam int unsigned RANK_REG_BITS = 16;
  localparam int unsigned LEVEL_BITS    = 32;
  localparam int unsigned WIDTH_BITS    = 47;
  localparam int unsigned REG_IDX_BITS  = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_BY_RANK = 2'd0,
    MODE_HIGHEST = 2'd1,
    MODE_CLOSEST = 2'd2
  } mode_e;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_SELECT_MODE     = 2'd0,
    REG_WANTED_RANK     = 2'd1,
    REG_TARGET_POSITION = 2'd2,
    REG_WINDOW_RANGE    = 2'd3
  } reg_idx_e;

endpackage

// File: rtl/core/plsel_channels.sv
// ----------------------------------------------------------------------------
// plsel channels
// Valid/ready channels of the peak list selector: peak input, selection
// output and register write port.
// ----------------------------------------------------------------------------
interface plsel_peak_if #(
  parameter int unsigned POS_BITS = plsel_pkg::POS_BITS_DEF
);
  logic                                    valid;
  logic                                    ready;
  logic                                    has_peak;
  logic signed [POS_BITS-1:0]              peak_position;
  logic signed [plsel_pkg::LEVEL_BITS-1:0] peak_level;
  logic        [plsel_pkg::WIDTH_BITS-1:0] peak_width;
  logic                                    list_end;

  modport source (
    output valid, has_peak, peak_position, peak_level, peak_width, list_end,
    input  ready
  );
  modport sink (
    input  valid, has_peak, peak_position, peak_level, peak_width, list_end,
    output ready
  );
endinterface

interface plsel_sel_if #(
  parameter int unsigned POS_BITS = plsel_pkg::POS_BITS_DEF
);
  logic                                    valid;
  logic                                    ready;
  logic                                    found;
  logic signed [POS_BITS-1:0]              sel_position;
  logic signed [plsel_pkg::LEVEL_BITS-1:0] sel_level;
  logic        [plsel_pkg::WIDTH_BITS-1:0] sel_width;

  modport source (
    output valid, found, sel_position, sel_level, sel_width,
    input  ready
  );
  modport sink (
    input  valid, found, sel_position, sel_level, sel_width,
    output ready
  );
endinterface

interface plsel_cfg_if #(
  parameter int unsigned DATA_BITS = plsel_pkg::POS_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic [plsel_pkg::REG_IDX_BITS-1:0]   index;
  logic [DATA_BITS-1:0]                 data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: rtl/core/peak_list_selector.sv
// ----------------------------------------------------------------------------
// peak_list_selector
// Picks one peak out of a magnitude-sorted peak list by rank, by first hit
// within a window around a target, or by least distance to the target in the window.
// ----------------------------------------------------------------------------
// Usage:
//   peak_i takes one peak per request; list_end marks the last item of a list
//   and an empty list is one request with has_peak low and list_end high.
//   sel_o gives one request per list, on its list_end item: found and the
//   chosen peak, or found low with zero payload.
//   cfg_i writes select_mode, wanted_rank, target_position and window_range
//   (index 0 to 3); it is always ready and is meant to be used while idle.
// Timing:
//   one peak per cycle unless a list_end item waits in the input register; a
//   list_end request passes through the input register, then the result register.
//   The single distance subtract and compare sits between those two
//   registers.
// Reset clears the running list, the pending result and the registers
// to their defaults (rank mode, wanted rank one, target and window zero).
// When sel_o stalls the result is held; further peaks of the next list are
// still taken until a second list_end item has to wait in the input register.
// ----------------------------------------------------------------------------
module peak_list_selector #(
  parameter int unsigned POS_BITS  = plsel_pkg::POS_BITS_DEF,
  parameter int unsigned RANK_BITS = plsel_pkg::RANK_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plsel_peak_if.sink   peak_i,
  plsel_sel_if.source  sel_o,
  plsel_cfg_if.sink    cfg_i
);

  localparam int unsigned CMP_BITS =
    (RANK_BITS > plsel_pkg::RANK_REG_BITS) ? RANK_BITS : plsel_pkg::RANK_REG_BITS;
  localparam int unsigned LVL_W = plsel_pkg::LEVEL_BITS;
  localparam int unsigned WID_W = plsel_pkg::WIDTH_BITS;

  // configuration registers
  logic [plsel_pkg::MODE_BITS-1:0]     mode_q;
  logic [plsel_pkg::RANK_REG_BITS-1:0] rank_q;
  logic [POS_BITS-1:0]                 target_q;
  logic [POS_BITS-2:0]                 range_q;

  // input register
  logic                in_valid_q;
  logic                in_has_q;
  logic [POS_BITS-1:0] in_pos_q;
  logic [LVL_W-1:0]    in_level_q;
  logic [WID_W-1:0]    in_width_q;
  logic                in_last_q;

  // running list state
  logic [RANK_BITS-1:0] count_q, count_d;
  logic                 have_q, have_d;
  logic [POS_BITS-1:0]  best_dist_q, best_dist_d;
  logic [POS_BITS-1:0]  best_pos_q, best_pos_d;
  logic [LVL_W-1:0]     best_level_q, best_level_d;
  logic [WID_W-1:0]     best_width_q, best_width_d;

  // result register
  logic                res_valid_q, res_valid_d;
  logic                res_found_q;
  logic [POS_BITS-1:0] res_pos_q;
  logic [LVL_W-1:0]    res_level_q;
  logic [WID_W-1:0]    res_width_q;

  logic                 advance;
  logic [POS_BITS-1:0]  key_pos, key_tgt, peak_dist;
  logic                 in_range, rank_hit, take;
  logic [RANK_BITS-1:0] count_inc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= plsel_pkg::MODE_BY_RANK;
      rank_q   <= plsel_pkg::RANK_REG_BITS'(1);
      target_q <= '0;
      range_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (plsel_pkg::reg_idx_e'(cfg_i.index))
        plsel_pkg::REG_SELECT_MODE:     mode_q   <= cfg_i.data[plsel_pkg::MODE_BITS-1:0];
        plsel_pkg::REG_WANTED_RANK:     rank_q   <= cfg_i.data[plsel_pkg::RANK_REG_BITS-1:0];
        plsel_pkg::REG_TARGET_POSITION: target_q <= cfg_i.data[POS_BITS-1:0];
        plsel_pkg::REG_WINDOW_RANGE:    range_q  <= cfg_i.data[POS_BITS-2:0];
      endcase
    end
  end

  // a list_end item waits only when the result register is still full and sel_o is not ready
  assign advance      = in_valid_q && (!in_last_q || !res_valid_q || sel_o.ready);
  assign peak_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (peak_i.ready) begin
      in_valid_q <= peak_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (peak_i.ready && peak_i.valid) begin
      in_has_q   <= peak_i.has_peak;
      in_pos_q   <= peak_i.peak_position;
      in_level_q <= peak_i.peak_level;
      in_width_q <= peak_i.peak_width;
      in_last_q  <= peak_i.list_end;
    end
  end

  // offset-binary keys turn the signed distance into unsigned compares
  assign key_pos   = in_pos_q ^ {1'b1, {(POS_BITS-1){1'b0}}};
  assign key_tgt   = target_q ^ {1'b1, {(POS_BITS-1){1'b0}}};
  assign peak_dist = (key_pos >= key_tgt) ? (key_pos - key_tgt) : (key_tgt - key_pos);

  assign in_range  = (range_q == '0) || ({1'b0, range_q} >= peak_dist);
  assign count_inc = (count_q == '1) ? count_q : count_q + RANK_BITS'(1);
  assign rank_hit  = (rank_q != '0) && (CMP_BITS'(count_inc) == CMP_BITS'(rank_q));

  always_comb begin
    unique case (plsel_pkg::mode_e'(mode_q))
      plsel_pkg::MODE_BY_RANK: take = !have_q && rank_hit;
      plsel_pkg::MODE_HIGHEST: take = !have_q && in_range;
      plsel_pkg::MODE_CLOSEST: take = in_range && (!have_q || (peak_dist < best_dist_q));
      default:                 take = 1'b0;
    endcase
  end

  // state after this peak has been judged
  always_comb begin
    count_d      = count_q;
    have_d       = have_q;
    best_dist_d  = best_dist_q;
    best_pos_d   = best_pos_q;
    best_level_d = best_level_q;
    best_width_d = best_width_q;
    if (in_has_q) begin
      count_d = count_inc;
      if (take) begin
        have_d       = 1'b1;
        best_dist_d  = peak_dist;
        best_pos_d   = in_pos_q;
        best_level_d = in_level_q;
        best_width_d = in_width_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      have_q  <= 1'b0;
    end else if (advance) begin
      if (in_last_q) begin
        count_q <= '0;
        have_q  <= 1'b0;
      end else begin
        count_q <= count_d;
        have_q  <= have_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      best_dist_q  <= best_dist_d;
      best_pos_q   <= best_pos_d;
      best_level_q <= best_level_d;
      best_width_q <= best_width_d;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance && in_last_q) begin
      res_valid_d = 1'b1;
    end else if (sel_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      res_found_q <= have_d;
      res_pos_q   <= have_d ? best_pos_d   : '0;
      res_level_q <= have_d ? best_level_d : '0;
      res_width_q <= have_d ? best_width_d : '0;
    end
  end

  assign sel_o.valid        = res_valid_q;
  assign sel_o.found        = res_found_q;
  assign sel_o.sel_position = res_pos_q;
  assign sel_o.sel_level    = res_level_q;
  assign sel_o.sel_width    = res_width_q;

endmodule

// File: rtl/core/plsel_checker.sv
// ----------------------------------------------------------------------------
// plsel_checker
// Port-level checks of the peak list selector, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plsel_checker #(
  parameter int unsigned POS_BITS = plsel_pkg::POS_BITS_DEF
) (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    in_last,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic                                    out_found,
  input logic [POS_BITS-1:0]                     out_position,
  input logic [plsel_pkg::LEVEL_BITS-1:0]        out_level,
  input logic [plsel_pkg::WIDTH_BITS-1:0]        out_width
);

  localparam int unsigned PAYLOAD_BITS =
    1 + POS_BITS + plsel_pkg::LEVEL_BITS + plsel_pkg::WIDTH_BITS;

  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [1:0]              pend_q;
  logic                    list_in, res_out;

  assign out_payload = {out_found, out_position, out_level, out_width};
  assign list_in     = in_valid && in_ready && in_last;
  assign res_out     = out_valid && out_ready;

  // list_end requests taken but whose result is not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (list_in && !res_out) begin
      pend_q <= pend_q + 2'd1;
    end else if (!list_in && res_out) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  `ASSERT_CLK(a_out_valid_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `ASSERT_CLK(a_out_payload_hold, out_valid && !out_ready |=> $stable(out_payload), "result changed while stalled")
  `ASSERT_NEVER(a_no_spurious_result, out_valid && (pend_q == 2'd0), "result without a list_end request")
  `ASSERT_NEVER(a_pend_bound, pend_q == 2'd3, "more than two lists in flight")

endmodule

bind peak_list_selector plsel_checker #(
  .POS_BITS(POS_BITS)
) u_plsel_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (peak_i.valid),
  .in_ready     (peak_i.ready),
  .in_last      (peak_i.list_end),
  .out_valid    (sel_o.valid),
  .out_ready    (sel_o.ready),
  .out_found    (sel_o.found),
  .out_position (sel_o.sel_position),
  .out_level    (sel_o.sel_level),
  .out_width    (sel_o.sel_width)
);
